>>> src/sic_pkg.sv
// Shared types and constants of the settle and interval checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sic_pkg;

    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned CHANGE_W = 13;
    localparam int unsigned COLOR_W = 11;
    localparam int unsigned ERR_W = 9;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 12'd50;

    // Interval grading bounds and drive levels.
    localparam logic [ERR_W-1:0] OCTAVE_SPAN = 9'd384;
    localparam logic [ERR_W-1:0] GREEN_LOW_LIMIT = 9'd3;
    localparam logic [ERR_W-1:0] GREEN_HIGH_LIMIT = 9'd381;
    localparam logic [ERR_W-1:0] BLUE_LOW_LIMIT = 9'd256;
    localparam logic [ERR_W-1:0] RED_HIGH_LIMIT = 9'd128;
    localparam logic [COLOR_W-1:0] COLOR_OFFSET = 11'd300;
    localparam logic [COLOR_W-1:0] GREEN_FULL = 11'd1024;

    typedef struct packed {
        logic color_write;
        logic [COLOR_W-1:0] red_level;
        logic [COLOR_W-1:0] green_level;
        logic [COLOR_W-1:0] blue_level;
        logic [ERR_W-1:0] interval_error;
    } sic_grade_t;

    typedef struct packed {
        logic settled;
        logic indicator_write;
        logic indicator_on;
        sic_grade_t grade;
    } sic_result_t;

endpackage

`default_nettype wire

>>> src/settle_and_interval_checker.sv
// Settle detector and interval grader for a slow control input.
// Depends on sic_pkg, sic_cell, sic_grader and sic_out_skid.
`default_nettype none

// The block takes one item per clock cycle while s_tready is high and gives one
// result item for each, formed combinationally and registered in the output
// buffer. Every accepted item shifts the delay line's row of WINDOW_DEPTH cells
// by one, and the running sum adds the new change and subtracts the oldest in a
// single adder. Results pass through a two-entry output buffer, so s_tready stays
// high while one result waits on m_tready and drops only when both entries are
// full. jump_threshold may be written at any time the block is idle; cfg_ready
// is always high.
module settle_and_interval_checker
    import sic_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data,       // jump_threshold
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,        // raw_level[11:0], smoothed_level[23:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,        // settled[0], indicator_on[1],
                                             // red_level[12:2], green_level[23:13],
                                             // blue_level[34:24], interval_error[43:35],
                                             // zero[47:44]
    output logic [1:0]       m_tuser         // indicator_write[0], color_write[1]
);

    localparam int unsigned SUM_W = CHANGE_W + $clog2(WINDOW_DEPTH);

    logic [LEVEL_W-1:0]         threshold_reg;
    logic [LEVEL_W-1:0]         threshold_next;
    logic                       settled_reg;
    logic                       settled_next;
    logic [LEVEL_W-1:0]         previous_reg;
    logic [LEVEL_W-1:0]         previous_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;

    logic                       accept;
    logic [LEVEL_W-1:0]         raw_level;
    logic [LEVEL_W-1:0]         smoothed_level;
    logic signed [CHANGE_W-1:0] change;
    logic                       jump;
    logic                       settle_hit;
    logic signed [CHANGE_W-1:0] push_val;
    logic signed [CHANGE_W-1:0] oldest;
    logic signed [SUM_W-1:0]    sum_updated;
    logic signed [CHANGE_W-1:0] chain [0:WINDOW_DEPTH];
    sic_grade_t                 grade;
    sic_result_t                result;
    sic_result_t                out_result;

    assign cfg_ready = 1'b1;
    assign accept = s_tvalid && s_tready;
    assign raw_level = s_tdata[11:0];
    assign smoothed_level = s_tdata[23:12];

    // 4095 - raw is the bitwise inverse of raw.
    assign change = $signed({1'b0, ~raw_level}) - $signed({1'b0, smoothed_level});
    assign jump = settled_reg && (change > $signed({1'b0, threshold_reg}));
    assign push_val = (!settled_reg || jump) ? change : '0;

    assign chain[0] = push_val;
    assign oldest = chain[WINDOW_DEPTH];

    generate
        for (genvar i = 0; i < WINDOW_DEPTH; i++)
        begin : g_cell
            sic_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .din      (chain[i]),
                .dout     (chain[i+1])
            );
        end
    endgenerate

    assign sum_updated = sum_reg
                         + {{(SUM_W-CHANGE_W){push_val[CHANGE_W-1]}}, push_val}
                         - {{(SUM_W-CHANGE_W){oldest[CHANGE_W-1]}}, oldest};

    // Settled when the window sum lies in 0..31, that is all bits from 5 up are zero.
    assign settle_hit = !settled_reg && (sum_updated[SUM_W-1:5] == '0);

    sic_grader u_grader (
        .current_level  (smoothed_level),
        .previous_level (previous_reg),
        .grade          (grade)
    );

    always_comb
    begin
        threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;
        settled_next = settled_reg;
        previous_next = previous_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            sum_next = sum_updated;
            if (settle_hit)
            begin
                settled_next = 1'b1;
            end
            else if (jump)
            begin
                settled_next = 1'b0;
                previous_next = smoothed_level;
            end
        end

        result = '0;
        result.settled = settle_hit || (settled_reg && !jump);
        result.indicator_write = settle_hit || jump;
        result.indicator_on = jump;
        if (settle_hit)
        begin
            result.grade = grade;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            settled_reg <= 1'b0;
            previous_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
            settled_reg <= settled_next;
            previous_reg <= previous_next;
            sum_reg <= sum_next;
        end
    end

    sic_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {4'b0000,
                      out_result.grade.interval_error,
                      out_result.grade.blue_level,
                      out_result.grade.green_level,
                      out_result.grade.red_level,
                      out_result.indicator_on,
                      out_result.settled};
    assign m_tuser = {out_result.grade.color_write, out_result.indicator_write};

endmodule

`default_nettype wire

>>> src/sic_cell.sv
// One stage of the change delay line: holds one signed change and passes it on.
// Depends on sic_pkg for the change width.
`default_nettype none

module sic_cell
    import sic_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       shift_en,
    input  wire logic signed [CHANGE_W-1:0] din,
    output logic signed [CHANGE_W-1:0]      dout
);

    logic signed [CHANGE_W-1:0] value_reg;
    logic signed [CHANGE_W-1:0] value_next;

    always_comb
    begin
        value_next = shift_en ? din : value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign dout = value_reg;

endmodule

`default_nettype wire

>>> src/sic_grader.sv
// Interval grader: distance between two levels modulo 384 and its color levels.
// Depends on sic_pkg for widths, bounds and the grade struct.
`default_nettype none

module sic_grader
    import sic_pkg::*;
(
    input  wire logic [LEVEL_W-1:0] current_level,
    input  wire logic [LEVEL_W-1:0] previous_level,
    output sic_grade_t              grade
);

    logic [LEVEL_W-1:0] level_diff;
    logic [4:0]         dist_hi;
    logic [8:0]         quot_scaled;
    logic [3:0]         quot;
    logic [LEVEL_W-1:0] quot_span;
    logic [LEVEL_W-1:0] rem_full;
    logic [ERR_W-1:0]   err;
    logic [ERR_W-1:0]   blue_dist;

    always_comb
    begin
        level_diff = (current_level >= previous_level) ? current_level - previous_level
                                                       : previous_level - current_level;
        // 384 is 3 * 128: divide the upper bits by 3 with the reciprocal 11/32,
        // which is exact for all 5-bit values.
        dist_hi = level_diff[LEVEL_W-1:7];
        quot_scaled = 9'(dist_hi) * 9'd11;
        quot = quot_scaled[8:5];
        quot_span = (LEVEL_W'(quot) << 8) + (LEVEL_W'(quot) << 7);
        rem_full = level_diff - quot_span;
        err = rem_full[ERR_W-1:0];
        blue_dist = OCTAVE_SPAN - err;

        grade = '0;
        grade.interval_error = err;
        if ((err < GREEN_LOW_LIMIT) || (err > GREEN_HIGH_LIMIT))
        begin
            grade.color_write = 1'b1;
            grade.green_level = GREEN_FULL;
        end
        else if (err > BLUE_LOW_LIMIT)
        begin
            grade.color_write = 1'b1;
            grade.blue_level = (COLOR_W'(blue_dist) << 3) + COLOR_OFFSET;
        end
        else if (err < RED_HIGH_LIMIT)
        begin
            grade.color_write = 1'b1;
            grade.red_level = (COLOR_W'(err) << 3) + COLOR_OFFSET;
        end
    end

endmodule

`default_nettype wire

>>> src/sic_out_skid.sv
// Two-entry output buffer that decouples the result register from the output stall.
// Depends on sic_pkg for the result struct.
`default_nettype none

module sic_out_skid
    import sic_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire sic_result_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output sic_result_t out_data
);

    logic        main_valid_reg;
    logic        main_valid_next;
    sic_result_t main_data_reg;
    sic_result_t main_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    sic_result_t skid_data_reg;
    sic_result_t skid_data_next;
    logic        pop;
    logic        push;

    assign in_ready = !skid_valid_reg;
    assign pop = main_valid_reg && out_ready;
    assign push = in_valid && !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_next = 1'b1;
                main_data_next = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next = in_data;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data = main_data_reg;

endmodule

`default_nettype wire
